>>> src/char_grid_blit_collide_assert.svh
// Assertion macros for the blit/collide block
`ifndef CHAR_GRID_BLIT_COLLIDE_ASSERT_SVH
`define CHAR_GRID_BLIT_COLLIDE_ASSERT_SVH
`ifndef SYNTHESIS
`define CGB_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CGB_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define CGB_ASSERT_IMPL(label, clk, rst_n, a, c)
`define CGB_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> src/cgb_pkg.sv
`timescale 1ns / 1ps
package cgb_pkg;
    localparam logic [7:0] SPACE = 8'h20;

    typedef enum logic [3:0] {
        CMD_WRBOARD = 4'd0,
        CMD_RDBOARD = 4'd1,
        CMD_WRPIECE = 4'd2,
        CMD_HIT     = 4'd3,
        CMD_MERGE   = 4'd4,
        CMD_STAMP   = 4'd5,
        CMD_CLEAR   = 4'd6,
        CMD_AND     = 4'd7,
        CMD_OR      = 4'd8,
        CMD_REPLACE = 4'd9,
        CMD_SWAP    = 4'd10
    } cmd_t;

    localparam logic [1:0] REG_BOARD_WIDTH  = 2'd0;
    localparam logic [1:0] REG_BOARD_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PIECE_WIDTH  = 2'd2;
    localparam logic [1:0] REG_PIECE_HEIGHT = 2'd3;

    typedef struct packed {
        logic [3:0]        command;
        logic signed [6:0] x;
        logic signed [6:0] y;
        logic signed [6:0] x2;
        logic signed [6:0] y2;
        logic [7:0]        value;
        logic [7:0]        value2;
    } cmd_beat_t;

    typedef struct packed {
        logic [7:0] read_value;
        logic       hit;
    } res_beat_t;

    typedef struct packed {
        logic [1:0] index;
        logic [6:0] data;
    } cfg_beat_t;
endpackage

>>> src/cgb_if.sv
`timescale 1ns / 1ps
interface cgb_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/char_grid_blit_collide.sv
`timescale 1ns / 1ps
// Command flow: board read/write and unknown commands visit one cell; swap reads two
// cells and writes both; piece commands walk each piece cell (4x4 by default) and
// whole-board commands walk each board cell in use; an empty walk finishes at once.
// One command at a time, a new one only once the last is done; the walker
// reuses one board port and one compare. Input waits while a result beat is unaccepted.
// Reset (rst_n, async, active low) restores the size registers; cell stores stay unset.
`include "char_grid_blit_collide_assert.svh"
module char_grid_blit_collide #(
    parameter int BOARD_W   = 64,
    parameter int BOARD_H   = 64,
    parameter int PIECE_MAX = 8
) (
    input  logic clk,
    input  logic rst_n,
    cgb_if.sink   cmd,
    cgb_if.source res,
    cgb_if.sink   cfg
);
    import cgb_pkg::*;

    localparam int BXW = (BOARD_W > 1) ? $clog2(BOARD_W) : 1;
    localparam int BYW = (BOARD_H > 1) ? $clog2(BOARD_H) : 1;
    localparam int PW  = (PIECE_MAX > 1) ? $clog2(PIECE_MAX) : 1;
    localparam int BAW = BXW + BYW;
    localparam int PAW = PW + PW;
    localparam int CW  = 10;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD, ST_RDW, ST_ACT, ST_WR2, ST_DONE
    } state_t;

    // Configuration
    logic [6:0] bw_reg, bh_reg;
    logic [3:0] pw_reg, ph_reg;
    cfg_beat_t  cfg_b;
    assign cfg_b = cfg.payload;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg <= 7'd64;
            bh_reg <= 7'd64;
            pw_reg <= 4'd4;
            ph_reg <= 4'd4;
        end
        else if (cfg.valid)
        begin
            case (cfg_b.index)
                REG_BOARD_WIDTH:  bw_reg <= cfg_b.data;
                REG_BOARD_HEIGHT: bh_reg <= cfg_b.data;
                REG_PIECE_WIDTH:  pw_reg <= cfg_b.data[3:0];
                REG_PIECE_HEIGHT: ph_reg <= cfg_b.data[3:0];
                default: ;
            endcase
        end
    end

    // Effective sizes
    logic signed [CW-1:0] ebw, ebh, epw, eph;
    always_comb
    begin
        ebw = (int'(bw_reg) < BOARD_W) ? CW'(bw_reg) : CW'(BOARD_W);
        ebh = (int'(bh_reg) < BOARD_H) ? CW'(bh_reg) : CW'(BOARD_H);
        epw = (int'(pw_reg) < PIECE_MAX) ? CW'(pw_reg) : CW'(PIECE_MAX);
        eph = (int'(ph_reg) < PIECE_MAX) ? CW'(ph_reg) : CW'(PIECE_MAX);
    end

    // Memories, addressed by {row, column}
    logic [7:0] board_mem [2**BAW];
    logic [7:0] piece_mem [2**PAW];
    logic [7:0] brd_q, pce_q;
    logic [BAW-1:0] b_raddr, b_waddr;
    logic [PAW-1:0] p_raddr, p_waddr;
    logic           b_we, p_we;
    logic [7:0]     b_wdata, p_wdata;

    always_ff @(posedge clk)
    begin
        if (b_we)
            board_mem[b_waddr] <= b_wdata;
        brd_q <= board_mem[b_raddr];
    end
    always_ff @(posedge clk)
    begin
        if (p_we)
            piece_mem[p_waddr] <= p_wdata;
        pce_q <= piece_mem[p_raddr];
    end

    // Command and walker registers
    state_t               state_reg;
    cmd_beat_t            c_reg;
    logic [CW-1:0]        j_reg, i_reg;
    logic                 hit_reg, phase_reg;
    logic [7:0]           a_reg;
    logic                 a_on_reg;
    res_beat_t            out_reg;
    logic                 out_v_reg;
    cmd_beat_t            cin;
    assign cin = cmd.payload;

    // Current target cell
    logic signed [CW-1:0] tx, ty;
    logic                 on_b, is_piece, is_bulk;
    always_comb
    begin
        is_piece = (c_reg.command == CMD_HIT) || (c_reg.command == CMD_MERGE)
                   || (c_reg.command == CMD_STAMP);
        is_bulk  = (c_reg.command == CMD_CLEAR) || (c_reg.command == CMD_AND)
                   || (c_reg.command == CMD_OR) || (c_reg.command == CMD_REPLACE);
        if (is_piece)
        begin
            tx = CW'(c_reg.x) + j_reg;
            ty = CW'(c_reg.y) + i_reg;
        end
        else if (is_bulk)
        begin
            tx = j_reg;
            ty = i_reg;
        end
        else if (phase_reg)
        begin
            tx = CW'(c_reg.x2);
            ty = CW'(c_reg.y2);
        end
        else
        begin
            tx = CW'(c_reg.x);
            ty = CW'(c_reg.y);
        end
        on_b = (tx >= 0) && (tx < ebw) && (ty >= 0) && (ty < ebh);
        b_raddr = {ty[BYW-1:0], tx[BXW-1:0]};
        p_raddr = {i_reg[PW-1:0], j_reg[PW-1:0]};
    end

    logic [7:0] bval;
    assign bval = on_b ? brd_q : SPACE;

    // Write decode in the action and second-write states
    logic [7:0] bulk_c;
    always_comb
    begin
        case (c_reg.command)
            CMD_CLEAR:   bulk_c = c_reg.value;
            CMD_AND:     bulk_c = brd_q & c_reg.value;
            CMD_OR:      bulk_c = brd_q | c_reg.value;
            default:     bulk_c = (brd_q == c_reg.value) ? c_reg.value2 : brd_q;
        endcase
        b_we = 1'b0;
        b_wdata = 8'h00;
        b_waddr = b_raddr;
        p_we = 1'b0;
        p_waddr = {c_reg.y[PW-1:0], c_reg.x[PW-1:0]};
        p_wdata = c_reg.value;
        if (state_reg == ST_ACT)
        begin
            case (c_reg.command)
                CMD_WRBOARD:
                begin
                    b_we = on_b;
                    b_wdata = c_reg.value;
                end
                CMD_WRPIECE:
                    p_we = (CW'(c_reg.x) >= 0) && (CW'(c_reg.x) < epw)
                           && (CW'(c_reg.y) >= 0) && (CW'(c_reg.y) < eph);
                CMD_MERGE, CMD_STAMP:
                begin
                    b_we = on_b && ((c_reg.command == CMD_STAMP) || (pce_q != SPACE));
                    b_wdata = pce_q;
                end
                CMD_CLEAR, CMD_AND, CMD_OR, CMD_REPLACE:
                begin
                    b_we = 1'b1;
                    b_wdata = bulk_c;
                end
                CMD_SWAP:
                begin
                    b_we = on_b;
                    b_wdata = a_reg;
                end
                default: ;
            endcase
        end
        else if (state_reg == ST_WR2)
        begin
            b_we = a_on_reg;
            b_wdata = bval;
            b_waddr = {c_reg.y[BYW-1:0], c_reg.x[BXW-1:0]};
        end
    end

    // Walk bounds
    logic [CW-1:0] wlim, hlim;
    logic          last_cell;
    assign wlim = is_bulk ? ebw : epw;
    assign hlim = is_bulk ? ebh : eph;
    assign last_cell = (j_reg + 1'b1 >= wlim) && (i_reg + 1'b1 >= hlim);

    assign cmd.ready = (state_reg == ST_IDLE) && (!out_v_reg || res.ready);
    assign res.valid = out_v_reg;
    assign res.payload = out_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
            out_reg <= '0;
            c_reg <= '0;
            a_reg <= 8'h00;
            j_reg <= '0;
            i_reg <= '0;
            hit_reg <= 1'b0;
            phase_reg <= 1'b0;
            a_on_reg <= 1'b0;
        end
        else
        begin
            if (res.valid && res.ready)
                out_v_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (cmd.valid && cmd.ready)
                    begin
                        c_reg <= cin;
                        j_reg <= '0;
                        i_reg <= '0;
                        hit_reg <= 1'b0;
                        phase_reg <= 1'b0;
                        state_reg <= ST_RD;
                    end
                ST_RD:
                begin
                    // empty walks finish at once
                    if ((is_piece || is_bulk) && ((wlim == 0) || (hlim == 0)))
                        state_reg <= ST_DONE;
                    else
                        state_reg <= ST_RDW;
                end
                ST_RDW:
                begin
                    if (c_reg.command == CMD_SWAP && !phase_reg)
                    begin
                        a_reg <= bval;
                        a_on_reg <= on_b;
                        phase_reg <= 1'b1;
                        state_reg <= ST_RD;
                    end
                    else
                        state_reg <= ST_ACT;
                end
                ST_ACT:
                begin
                    if (c_reg.command == CMD_HIT && pce_q != SPACE && bval != SPACE)
                        hit_reg <= 1'b1;
                    if (c_reg.command == CMD_SWAP)
                        state_reg <= ST_WR2;
                    else if ((is_piece || is_bulk) && !last_cell)
                    begin
                        if (j_reg + 1'b1 >= wlim)
                        begin
                            j_reg <= '0;
                            i_reg <= i_reg + 1'b1;
                        end
                        else
                            j_reg <= j_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                    else
                        state_reg <= ST_DONE;
                end
                ST_WR2:
                    state_reg <= ST_DONE;
                ST_DONE:
                begin
                    out_reg.read_value <= (c_reg.command == CMD_RDBOARD) ? a_reg : 8'h00;
                    out_reg.hit <= (c_reg.command == CMD_HIT) && hit_reg;
                    out_v_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (state_reg == ST_RDW && c_reg.command == CMD_RDBOARD)
                a_reg <= bval;
        end
    end

    // Assertions
    `CGB_ASSERT_IMPL(a_busy_not_ready, clk, rst_n, state_reg != ST_IDLE, !cmd.ready)
    `CGB_ASSERT_NEXT(a_done_gives_result, clk, rst_n, state_reg == ST_DONE, out_v_reg)
    `CGB_ASSERT_IMPL(a_hit_only_for_hit, clk, rst_n, out_v_reg && out_reg.hit,
                     c_reg.command == CMD_HIT)
endmodule
